/* rtl/rdde_pkg.sv */
// ----------------------------------------------------------------------------
// rdde_pkg
// Types and codes shared by the reversible deque drop engine and its parts.
// ----------------------------------------------------------------------------
package rdde_pkg;

	localparam int CMD_W   = 3;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 11;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DROP    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_ERROR = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic               data_valid;
		logic [VAL_W-1:0]   read_value;
		logic               last;
		logic [COUNT_W-1:0] count;
	} rsp_t;

endpackage

/* rtl/reversible_deque_drop_engine.sv */
// ----------------------------------------------------------------------------
// reversible_deque_drop_engine
// Double-ended element buffer with a lazy reverse flag, held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (req: command and value) is taken at a rising edge where
//   start is high and busy is low. Exactly one result word (rsp) follows on
//   the next cycle, marked by done for that single cycle; the receiver
//   cannot hold it off, so it must sample rsp whenever done is high.
//   A new command may be given in every cycle in which busy is low, so
//   throughput is one command per cycle while busy is low. A read issues
//   its RAM read at the accepting edge and the registered RAM output forms
//   read_value in the result cycle; a push writes the RAM at the accepting
//   edge, so a following read of the same entry sees the new element.
//   Reset clears the list, the reverse and error flags and any pending
//   result; busy is high during reset and until the first edge after it.
//   The element RAM is not cleared: only written entries are ever read.
// ----------------------------------------------------------------------------
module reversible_deque_drop_engine #(
	parameter int DEPTH      = 1024,
	parameter int VALUE_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  rdde_pkg::req_t   req,
	output logic             done,
	output rdde_pkg::rsp_t   rsp
);

	localparam int AW = $clog2(DEPTH);

	logic                  busy_q;
	logic                  accept;
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic                  mem_re;
	logic [AW-1:0]         mem_raddr;
	logic [VALUE_BITS-1:0] mem_wdata;
	logic [VALUE_BITS-1:0] mem_rdata;
	logic                  done_q;
	logic [rdde_pkg::STAT_W-1:0]  status_q;
	logic                  valid_q;
	logic                  last_q;
	logic [rdde_pkg::COUNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy      = busy_q;
	assign accept    = start && !busy_q;
	assign mem_wdata = VALUE_BITS'(req.value);

	rdde_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.command   (req.command),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.done_q    (done_q),
		.status_q  (status_q),
		.valid_q   (valid_q),
		.last_q    (last_q),
		.count_q   (count_q)
	);

	rdde_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign done = done_q;

	always_comb begin
		rsp.status     = status_q;
		rsp.data_valid = valid_q;
		rsp.read_value = valid_q ? rdde_pkg::VAL_W'(mem_rdata) : '0;
		rsp.last       = last_q;
		rsp.count      = count_q;
	end

`ifndef NO_ASSERTIONS
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted word produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result without an accepted word");

	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.data_valid) |-> (rsp.status == rdde_pkg::ST_OK))
		else $error("popped element reported with a failing status");

	a_last_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.last) |-> (rsp.data_valid && rsp.count == '0))
		else $error("last element flagged while elements remain");
`endif

endmodule

/* rtl/rdde_ram.sv */
// ----------------------------------------------------------------------------
// rdde_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rdde_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/rdde_ctrl.sv */
// ----------------------------------------------------------------------------
// rdde_ctrl
// Pointer and flag state of the deque, command decode and memory addressing.
// ----------------------------------------------------------------------------
module rdde_ctrl #(
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic [rdde_pkg::CMD_W-1:0] command,
	output logic                     mem_we,
	output logic [$clog2(DEPTH)-1:0] mem_waddr,
	output logic                     mem_re,
	output logic [$clog2(DEPTH)-1:0] mem_raddr,
	output logic                     done_q,
	output logic [rdde_pkg::STAT_W-1:0]  status_q,
	output logic                     valid_q,
	output logic                     last_q,
	output logic [rdde_pkg::COUNT_W-1:0] count_q
);

	localparam int AW = $clog2(DEPTH);
	localparam int PW = AW + 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          rev_q, rev_d;
	logic          err_q, err_d;
	logic [rdde_pkg::STAT_W-1:0] status_d;
	logic          valid_d;
	logic          last_d;
	logic [AW-1:0] tail_pos;
	logic [AW-1:0] back_pos;
	logic [AW-1:0] head_next;

	function automatic logic [AW-1:0] wrap(input logic [PW-1:0] p);
		wrap = (p >= PW'(DEPTH)) ? AW'(p - PW'(DEPTH)) : AW'(p);
	endfunction

	always_comb begin
		tail_pos  = wrap(PW'(head_q) + PW'(cnt_q));
		back_pos  = wrap(PW'(head_q) + PW'(cnt_q) - PW'(1));
		head_next = wrap(PW'(head_q) + PW'(1));
	end

	always_comb begin
		head_d    = head_q;
		cnt_d     = cnt_q;
		rev_d     = rev_q;
		err_d     = err_q;
		status_d  = rdde_pkg::ST_OK;
		valid_d   = 1'b0;
		last_d    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = tail_pos;
		mem_re    = 1'b0;
		mem_raddr = rev_q ? back_pos : head_q;
		unique case (command)
			rdde_pkg::CMD_CLEAR: begin
				head_d = '0;
				cnt_d  = '0;
				rev_d  = 1'b0;
				err_d  = 1'b0;
			end
			rdde_pkg::CMD_PUSH: begin
				if (cnt_q == CW'(DEPTH)) begin
					status_d = rdde_pkg::ST_FULL;
				end else begin
					mem_we = accept;
					cnt_d  = cnt_q + CW'(1);
				end
			end
			rdde_pkg::CMD_REVERSE: begin
				rev_d = ~rev_q;
			end
			rdde_pkg::CMD_DROP: begin
				if (err_q) begin
					status_d = rdde_pkg::ST_ERROR;
				end else if (cnt_q == '0) begin
					err_d    = 1'b1;
					status_d = rdde_pkg::ST_ERROR;
				end else begin
					if (!rev_q) begin
						head_d = head_next;
					end
					cnt_d = cnt_q - CW'(1);
				end
			end
			rdde_pkg::CMD_READ: begin
				if (err_q) begin
					status_d = rdde_pkg::ST_ERROR;
				end else if (cnt_q == '0) begin
					status_d = rdde_pkg::ST_EMPTY;
				end else begin
					mem_re  = accept;
					valid_d = 1'b1;
					last_d  = (cnt_q == CW'(1));
					if (!rev_q) begin
						head_d = head_next;
					end
					cnt_d = cnt_q - CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
			rev_q  <= 1'b0;
			err_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				head_q <= head_d;
				cnt_q  <= cnt_d;
				rev_q  <= rev_d;
				err_q  <= err_d;
			end
		end
	end

	// Result fields carry no reset; they are qualified by the strobe.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			valid_q  <= valid_d;
			last_q   <= last_d;
			count_q  <= rdde_pkg::COUNT_W'(cnt_d);
		end
	end

endmodule
